// ===== sv/skbs_pkg.sv =====
// Shared types, constants and a helper function for the sorted key search block.
`timescale 1ns / 1ps

package skbs_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;

	// Register port geometry: one register word, plus one word address bit.
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-3:0] REG_ENTRY_COUNT = '0;

	// Command codes carried by a request word.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Request word: one load or one search.
	typedef struct packed {
		logic                    command;
		logic [SLOT_W-1:0]       slot_index;
		logic signed [KEY_W-1:0] key_value;
	} req_t;

	// Response word: one per search.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] position;
	} rsp_t;

	// Search sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_STEP,
		ST_DONE
	} state_t;

	// Which range bound the port A read of the last step refreshed.
	typedef enum logic [1:0] {
		BSEL_NONE,
		BSEL_LO,
		BSEL_HI
	} bsel_t;

	// Middle slot of the range [lo, hip - 1]; valid only when lo < hip.
	function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
			input logic [CNT_W-1:0] hip);
		logic [CNT_W-1:0] span;
		span = hip - lo - CNT_W'(1);
		return lo + (span >> 1);
	endfunction

endpackage

// ===== sv/skbs_engine.sv =====
// Key table memory and the binary search sequencer with its response register.
`timescale 1ns / 1ps

module skbs_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [skbs_pkg::CNT_W-1:0] entry_count,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  skbs_pkg::req_t            req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output skbs_pkg::rsp_t            rsp
);
	import skbs_pkg::*;

	// Key table: two synchronous read ports, one write port.
	logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic signed [KEY_W-1:0] rd_a_q;
	logic signed [KEY_W-1:0] rd_b_q;

	state_t state_q;
	state_t state_d;

	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hip_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] klo_q;
	logic signed [KEY_W-1:0] khi_q;
	bsel_t                   bsel_q;
	rsp_t                    res_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    req_fire;
	logic [CNT_W-1:0]        cnt_sat;
	logic [CNT_W-1:0]        mid_cur;
	logic signed [KEY_W-1:0] klo_eff;
	logic signed [KEY_W-1:0] khi_eff;
	logic                    below;
	logic                    above;
	logic                    hit;
	logic                    go_up;
	logic [CNT_W-1:0]        lo_n;
	logic [CNT_W-1:0]        hip_n;
	logic                    range_empty;
	logic                    step_stop;
	logic [CNT_W-1:0]        mid_n;
	logic [CNT_W-1:0]        hi_n;
	logic [CNT_W-1:0]        last_slot;

	logic [SLOT_W-1:0]       addr_a;
	logic [SLOT_W-1:0]       addr_b;
	logic                    mem_we;
	logic                    rsp_load;

	assign req_fire  = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);

	// Count of keys in use, limited to the table depth.
	assign cnt_sat   = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;
	assign last_slot = cnt_sat - CNT_W'(1);

	// One search step: bound check against the cached or freshly read bound keys,
	// then compare with the middle key and narrow the range.
	assign mid_cur     = mid_of(lo_q, hip_q);
	assign klo_eff     = (bsel_q == BSEL_LO) ? rd_a_q : klo_q;
	assign khi_eff     = (bsel_q == BSEL_HI) ? rd_a_q : khi_q;
	assign below       = key_q < klo_eff;
	assign above       = key_q > khi_eff;
	assign hit         = key_q == rd_b_q;
	assign go_up       = key_q > rd_b_q;
	assign lo_n        = go_up ? (mid_cur + CNT_W'(1)) : lo_q;
	assign hip_n       = go_up ? hip_q : mid_cur;
	assign hi_n        = hip_n - CNT_W'(1);
	assign range_empty = lo_n >= hip_n;
	assign step_stop   = below || above || hit || range_empty;
	assign mid_n       = mid_of(lo_n, hip_n);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && req.command == CMD_SEARCH) begin
					state_d = (cnt_sat == '0) ? ST_DONE : ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (step_stop) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory addresses and strobes for each state.
	always_comb begin
		addr_a   = '0;
		addr_b   = '0;
		mem_we   = 1'b0;
		rsp_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mem_we = req_fire && req.command == CMD_LOAD;
				addr_a = '0;
				addr_b = last_slot[SLOT_W-1:0];
			end
			ST_PRIME: begin
				addr_b = mid_cur[SLOT_W-1:0];
			end
			ST_STEP: begin
				addr_a = go_up ? lo_n[SLOT_W-1:0] : hi_n[SLOT_W-1:0];
				addr_b = mid_n[SLOT_W-1:0];
			end
			ST_DONE: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
				addr_a = '0;
			end
		endcase
	end

	// Key table write and registered reads.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[req.slot_index] <= req.key_value;
		end
		rd_a_q <= key_mem[addr_a];
		rd_b_q <= key_mem[addr_b];
	end

	// Search datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= req.key_value;
				lo_q  <= '0;
				hip_q <= cnt_sat;
				res_q <= '0;
			end
			ST_PRIME: begin
				klo_q  <= rd_a_q;
				khi_q  <= rd_b_q;
				bsel_q <= BSEL_NONE;
			end
			ST_STEP: begin
				klo_q  <= klo_eff;
				khi_q  <= khi_eff;
				lo_q   <= lo_n;
				hip_q  <= hip_n;
				bsel_q <= go_up ? BSEL_LO : BSEL_HI;
				if (hit && !below && !above) begin
					res_q <= '{found: 1'b1, position: mid_cur[SLOT_W-1:0]};
				end else begin
					res_q <= '0;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// State register and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response word register.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/sorted_key_binary_search.sv =====
// An accepted search runs ST_PRIME, one ST_STEP per probe (1 to 5 probes), then ST_DONE,
// which loads the response register once it is free and so raises rsp_valid; an empty table
// goes straight to ST_DONE. A new search is taken only when idle again; one memory probe
// per cycle uses the two read ports of the key table; a load is taken every cycle while idle.
// Reset: entry_count clears to zero and the sequencer goes idle; the key table is not cleared,
// so every slot must be loaded before a search reaches it.
`timescale 1ns / 1ps

module sorted_key_binary_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [skbs_pkg::ADDR_W-1:0]     paddr,
	input  logic [skbs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [skbs_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  skbs_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output skbs_pkg::rsp_t                 rsp
);
	import skbs_pkg::*;

	logic [CNT_W-1:0] entry_count_q;
	logic             reg_sel;
	logic             reg_wr;

	// Register decode on the word address.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_ENTRY_COUNT);
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (reg_wr) begin
			entry_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// Register read data.
	assign prdata = reg_sel ? {{(APB_DATA_W - CNT_W){1'b0}}, entry_count_q} : '0;

	// Key table and search sequencer.
	skbs_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count_q),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule
